### src/md5_digest_engine_core_defines.svh
// Assertion helpers for the digest engine.
`ifndef MD5_DIGEST_ENGINE_CORE_DEFINES_SVH
`define MD5_DIGEST_ENGINE_CORE_DEFINES_SVH

// same-cycle implication
`define MD5DE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("md5de assertion failed");

// next-cycle implication
`define MD5DE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("md5de assertion failed");

`endif

### src/md5de_pkg.sv
package md5de_pkg;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } abcd_t;

  localparam abcd_t MD5DE_IV = '{
    a: 32'h67452301,
    b: 32'hefcdab89,
    c: 32'h98badcfe,
    d: 32'h10325476
  };

  localparam int unsigned BUF_WORDS = 16;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] K_ROM [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] S_ROM [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // message word used by a round
  function automatic logic [3:0] md5de_msg_index(input logic [5:0] r);
    logic [3:0] rl;
    logic [3:0] g;
    rl = r[3:0];
    case (r[5:4])
      2'd0:    g = rl;
      2'd1:    g = 4'(rl * 4'd5 + 4'd1);
      2'd2:    g = 4'(rl * 4'd3 + 4'd5);
      default: g = 4'(rl * 4'd7);
    endcase
    return g;
  endfunction

  function automatic logic [4:0] md5de_shift(input logic [5:0] r);
    return S_ROM[{r[5:4], r[1:0]}];
  endfunction

endpackage

### src/md5de_in_if.sv
interface md5de_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink (input valid, input kind, input data_byte, output ready);
endinterface

### src/md5de_out_if.sv
interface md5de_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface

### src/md5de_ram.sv
module md5de_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/md5de_round.sv
module md5de_round
  import md5de_pkg::*;
(
  input  logic [5:0]  rnd_i,
  input  abcd_t       abcd_i,
  input  logic [31:0] msg_word_i,
  output abcd_t       abcd_o
);

  logic [31:0] f;
  logic [31:0] sum;
  logic [63:0] rot_wide;
  logic [4:0]  sh;

  always_comb begin
    case (rnd_i[5:4])
      2'd0:    f = (abcd_i.b & abcd_i.c) | (~abcd_i.b & abcd_i.d);
      2'd1:    f = (abcd_i.b & abcd_i.d) | (abcd_i.c & ~abcd_i.d);
      2'd2:    f = abcd_i.b ^ abcd_i.c ^ abcd_i.d;
      default: f = abcd_i.c ^ (abcd_i.b | ~abcd_i.d);
    endcase
  end

  assign sum      = abcd_i.a + f + K_ROM[rnd_i] + msg_word_i;
  assign sh       = md5de_shift(rnd_i);
  // rotate left: upper half of the doubled word after the shift
  assign rot_wide = {sum, sum} << sh;

  assign abcd_o.a = abcd_i.d;
  assign abcd_o.b = abcd_i.b + rot_wide[63:32];
  assign abcd_o.c = abcd_i.b;
  assign abcd_o.d = abcd_i.c;

endmodule

### src/md5de_out_stage.sv
module md5de_out_stage
  import md5de_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  abcd_t       digest_i,
  output logic        busy_o,
  md5de_out_if.source dig_o
);

  abcd_t      dig_q;
  logic       busy_q, busy_d;
  logic [1:0] cnt_q, cnt_d;
  logic       hs;

  assign hs = busy_q && dig_o.ready;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (load_i) begin
      busy_d = 1'b1;
      cnt_d  = 2'd0;
    end else if (hs) begin
      cnt_d = cnt_q + 2'd1;
      if (cnt_q == 2'd3) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      dig_q <= digest_i;
    end
  end

  always_comb begin
    case (cnt_q)
      2'd0:    dig_o.digest_word = dig_q.a;
      2'd1:    dig_o.digest_word = dig_q.b;
      2'd2:    dig_o.digest_word = dig_q.c;
      default: dig_o.digest_word = dig_q.d;
    endcase
  end

  assign dig_o.valid      = busy_q;
  assign dig_o.word_index = cnt_q;
  assign dig_o.last_word  = (cnt_q == 2'd3);
  assign busy_o           = busy_q;

endmodule

### src/md5_digest_engine_core.sv
// Byte beat: a full block starts compression (load, 64 rounds, fold). Finish beat: pad
// word, then zeros and the length to fill the block, then compression; a pad that spills
// into a second block fills and compresses that one too; then a wait until the previous
// digest drains, to hand over. Digest: four words, one per cycle while the sink is ready.
// No byte is taken during compression (shared rounds). Reset: control clears, chaining
// words take the initial value, bit count is zero; the block buffer RAM is not cleared.
`include "md5_digest_engine_core_defines.svh"

module md5_digest_engine_core
  import md5de_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  md5de_in_if.sink   msg_i,
  md5de_out_if.source dig_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FILL  = 3'd1;
  localparam logic [2:0] ST_LOAD  = 3'd2;
  localparam logic [2:0] ST_ROUND = 3'd3;
  localparam logic [2:0] ST_FOLD  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  localparam int unsigned AW = $clog2(BUF_WORDS);

  logic [2:0]    state_q, state_d;
  logic [5:0]    rnd_q, rnd_d;
  logic [AW:0]   wp_q, wp_d;
  logic          two_q, two_d;
  logic          fin_q, fin_d;
  logic [63:0]   bit_cnt_q, bit_cnt_d;
  logic [31:0]   wacc_q, wacc_d;
  abcd_t         abcd_q, abcd_d;
  abcd_t         chain_q, chain_d;
  abcd_t         rnd_out;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  logic          in_hs;
  logic [5:0]    idx;
  logic [1:0]    lane;
  logic [31:0]   pad_word;
  logic [31:0]   fill_word;
  logic          out_load;
  logic          out_busy;

  assign msg_i.ready = (state_q == ST_IDLE);
  assign in_hs       = msg_i.valid && msg_i.ready;
  assign idx         = bit_cnt_q[8:3];
  assign lane        = idx[1:0];

  // partial word: bytes below the pad position kept, pad marker, zeros above
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (2'(i) < lane) begin
        pad_word[8*i +: 8] = wacc_q[8*i +: 8];
      end else if (2'(i) == lane) begin
        pad_word[8*i +: 8] = PAD_BYTE;
      end else begin
        pad_word[8*i +: 8] = 8'h00;
      end
    end
  end

  // length goes in the last two words of the final block only
  always_comb begin
    fill_word = 32'h0;
    if (!two_q) begin
      if (wp_q[AW-1:0] == AW'(BUF_WORDS - 2)) begin
        fill_word = bit_cnt_q[31:0];
      end else if (wp_q[AW-1:0] == AW'(BUF_WORDS - 1)) begin
        fill_word = bit_cnt_q[63:32];
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    rnd_d     = rnd_q;
    wp_d      = wp_q;
    two_d     = two_q;
    fin_d     = fin_q;
    bit_cnt_d = bit_cnt_q;
    wacc_d    = wacc_q;
    abcd_d    = abcd_q;
    chain_d   = chain_q;
    ram_we    = 1'b0;
    ram_waddr = idx[5:2];
    ram_wdata = pad_word;
    ram_raddr = '0;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_hs) begin
          if (!msg_i.kind) begin
            wacc_d[8*lane +: 8] = msg_i.data_byte;
            bit_cnt_d           = bit_cnt_q + 64'd8;
            if (lane == 2'd3) begin
              ram_we    = 1'b1;
              ram_wdata = {msg_i.data_byte, wacc_q[23:0]};
            end
            if (idx == 6'd63) begin
              state_d = ST_LOAD;
            end
          end else begin
            ram_we  = 1'b1;
            wp_d    = (AW+1)'(idx[5:2]) + (AW+1)'(1);
            // no room for the length after the pad byte
            two_d   = (idx[5:2] >= AW'(BUF_WORDS - 2));
            fin_d   = 1'b1;
            state_d = ST_FILL;
          end
        end
      end
      ST_FILL: begin
        if (wp_q[AW]) begin
          state_d = ST_LOAD;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = wp_q[AW-1:0];
          ram_wdata = fill_word;
          wp_d      = wp_q + (AW+1)'(1);
        end
      end
      ST_LOAD: begin
        ram_raddr = md5de_msg_index(6'd0);
        abcd_d    = chain_q;
        rnd_d     = 6'd0;
        state_d   = ST_ROUND;
      end
      ST_ROUND: begin
        // prefetch next round's word; read data arrives as the round advances
        ram_raddr = md5de_msg_index(rnd_q + 6'd1);
        abcd_d    = rnd_out;
        rnd_d     = rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        chain_d.a = chain_q.a + abcd_q.a;
        chain_d.b = chain_q.b + abcd_q.b;
        chain_d.c = chain_q.c + abcd_q.c;
        chain_d.d = chain_q.d + abcd_q.d;
        if (fin_q) begin
          if (two_q) begin
            two_d   = 1'b0;
            wp_d    = '0;
            state_d = ST_FILL;
          end else begin
            state_d = ST_DONE;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DONE: begin
        if (!out_busy) begin
          out_load  = 1'b1;
          chain_d   = MD5DE_IV;
          bit_cnt_d = '0;
          fin_d     = 1'b0;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rnd_q     <= '0;
      wp_q      <= '0;
      two_q     <= 1'b0;
      fin_q     <= 1'b0;
      bit_cnt_q <= '0;
      chain_q   <= MD5DE_IV;
    end else begin
      state_q   <= state_d;
      rnd_q     <= rnd_d;
      wp_q      <= wp_d;
      two_q     <= two_d;
      fin_q     <= fin_d;
      bit_cnt_q <= bit_cnt_d;
      chain_q   <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wacc_q <= wacc_d;
    abcd_q <= abcd_d;
  end

  md5de_ram #(
    .Width(32),
    .Depth(BUF_WORDS)
  ) u_buf (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  md5de_round u_round (
    .rnd_i     (rnd_q),
    .abcd_i    (abcd_q),
    .msg_word_i(ram_rdata),
    .abcd_o    (rnd_out)
  );

  md5de_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (out_load),
    .digest_i(chain_q),
    .busy_o  (out_busy),
    .dig_o   (dig_o)
  );

  `MD5DE_ASSERT_NXT(a_byte_count, clk_i, rst_ni, in_hs && !msg_i.kind, bit_cnt_q == $past(bit_cnt_q) + 64'd8)
  `MD5DE_ASSERT_IMP(a_no_wr_in_compress, clk_i, rst_ni, state_q == ST_LOAD || state_q == ST_ROUND || state_q == ST_FOLD, !ram_we)
  `MD5DE_ASSERT_NXT(a_restart_after_digest, clk_i, rst_ni, out_load, chain_q == MD5DE_IV && bit_cnt_q == 64'd0 && dig_o.valid)

endmodule
